FILE: src/vgmct_pkg.sv
// Shared types, codes and constants of the VGM command transcoder.
package vgmct_pkg;

  localparam logic [14:0] BANK_BYTES = 15'd16383;
  localparam logic [8:0]  MAX_BANKS  = 9'd255;

  localparam logic [31:0] START_OFFSET = 32'h0000_00C0;
  localparam logic [3:0]  SKIP_BYTES   = 4'd8;

  // input command codes
  localparam logic [7:0] CMD_REG_WR    = 8'hB3;
  localparam logic [7:0] CMD_WAIT_N    = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
  localparam logic [7:0] CMD_END       = 8'h66;
  localparam logic [7:0] CMD_DATA_BLK  = 8'h67;

  // output command codes
  localparam logic [7:0] OUT_REG_WR  = 8'h80;
  localparam logic [7:0] OUT_WAIT    = 8'h40;
  localparam logic [7:0] OUT_BANK_SW = 8'h20;
  localparam logic [7:0] OUT_LOOP    = 8'h10;
  localparam logic [7:0] OUT_END     = 8'h08;
  localparam logic [7:0] ADDR_BIAS   = 8'h10;
  localparam logic [7:0] ONE_FRAME   = 8'h01;

  // frames = samples * rate / 44100, via reciprocal 2^32 / 44100
  localparam logic [16:0] DIV_RECIP = 17'd97391;
  localparam logic [15:0] FRAME_DIV = 16'd44100;
  localparam logic [15:0] ROUND_MIN = 16'd43659;   // 0.99 * 44100
  localparam logic [9:0]  FRAME_MAX = 10'd255;

  localparam logic [1:0] REG_TICK_RATE = 2'd0;
  localparam logic [1:0] REG_LOOP_OFS  = 2'd1;
  localparam logic [1:0] REG_SYNC      = 2'd2;

  localparam logic [7:0]  RATE_RESET = 8'd50;
  localparam logic [7:0]  SYNC_RESET = 8'd128;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    FLT_NONE,
    FLT_UNKNOWN,
    FLT_INEXACT,
    FLT_RANGE
  } fault_t;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_WR_ADDR,
    PH_WR_VAL,
    PH_WAIT_LO,
    PH_WAIT_HI,
    PH_SKIP,
    PH_DB_VAL
  } phase_t;

  typedef enum logic [2:0] {
    OP_CMD,
    OP_END,
    OP_BAD,
    OP_DATA,
    OP_WAIT
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] first;       // wait: samples low byte
    logic [7:0] second;      // wait: samples high byte
    logic       has_second;
    logic       at_loop;
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROOM,
    BK_FIRST,
    BK_SECOND,
    BK_MUL,
    BK_DIV,
    BK_REM,
    BK_FIX
  } bk_state_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  emitted_byte;
    logic [7:0]  bank_number;
    logic [13:0] bank_position;
    logic        loop_seen;
    logic [14:0] loop_cpu_address;
    logic [7:0]  loop_bank;
    logic        song_done;
    fault_t      fault;
    logic        run_last;
  } res_t;

endpackage

FILE: src/vgmct_regs.sv
// Configuration register file on the APB-style port.
module vgmct_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  tick_rate,
  output logic [31:0] loop_offset,
  output logic [7:0]  sync_reg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate   <= vgmct_pkg::RATE_RESET;
      loop_offset <= '0;
      sync_reg    <= vgmct_pkg::SYNC_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        vgmct_pkg::REG_TICK_RATE: tick_rate   <= pwdata[7:0];
        vgmct_pkg::REG_LOOP_OFS:  loop_offset <= pwdata;
        vgmct_pkg::REG_SYNC:      sync_reg    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      vgmct_pkg::REG_TICK_RATE: prdata = {24'd0, tick_rate};
      vgmct_pkg::REG_LOOP_OFS:  prdata = loop_offset;
      vgmct_pkg::REG_SYNC:      prdata = {24'd0, sync_reg};
      default:                  prdata = '0;
    endcase
  end

endmodule

FILE: src/vgmct_front.sv
// Front end: parses song bytes and queues decoded operations.
module vgmct_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       song_byte,
  output logic             full,
  input  logic [31:0]      loop_offset,
  input  logic [7:0]       sync_reg,
  output logic             op_valid,
  output vgmct_pkg::op_t   op,
  input  logic             op_pop
);

  vgmct_pkg::phase_t phase, phase_next;
  logic [3:0]  skip_count, skip_next;
  logic [3:0]  skip_dec;
  logic [7:0]  wait_lo, wait_lo_next;
  logic [31:0] stream_offset;
  logic        accept;
  logic        at_loop;
  logic        gen;
  vgmct_pkg::op_t op_new;
  logic        op_push;

  vgmct_pkg::op_t              q_mem [vgmct_pkg::QUEUE_DEPTH];
  logic [vgmct_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [vgmct_pkg::QPTR_W:0]   count;

  assign accept   = push & ~full;
  assign at_loop  = (loop_offset != 32'd0) && (stream_offset == loop_offset);
  assign skip_dec = (skip_count != 4'd0) ? skip_count - 4'd1 : 4'd0;

  always_comb begin
    phase_next   = phase;
    skip_next    = skip_count;
    wait_lo_next = wait_lo;
    if (accept) begin
      unique case (phase)
        vgmct_pkg::PH_CMD: begin
          if (song_byte == vgmct_pkg::CMD_REG_WR) begin
            phase_next = vgmct_pkg::PH_WR_ADDR;
          end else if (song_byte == vgmct_pkg::CMD_WAIT_N) begin
            phase_next = vgmct_pkg::PH_WAIT_LO;
          end else if (song_byte == vgmct_pkg::CMD_DATA_BLK) begin
            skip_next  = vgmct_pkg::SKIP_BYTES;
            phase_next = vgmct_pkg::PH_SKIP;
          end
        end
        vgmct_pkg::PH_WR_ADDR: phase_next = vgmct_pkg::PH_WR_VAL;
        vgmct_pkg::PH_WR_VAL:  phase_next = vgmct_pkg::PH_CMD;
        vgmct_pkg::PH_WAIT_LO: begin
          wait_lo_next = song_byte;
          phase_next   = vgmct_pkg::PH_WAIT_HI;
        end
        vgmct_pkg::PH_WAIT_HI: phase_next = vgmct_pkg::PH_CMD;
        vgmct_pkg::PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == 4'd0) begin
            phase_next = vgmct_pkg::PH_DB_VAL;
          end
        end
        vgmct_pkg::PH_DB_VAL:  phase_next = vgmct_pkg::PH_CMD;
        default:               phase_next = vgmct_pkg::PH_CMD;
      endcase
    end
  end

  always_comb begin
    gen               = 1'b0;
    op_new.kind       = vgmct_pkg::OP_DATA;
    op_new.first      = song_byte;
    op_new.second     = '0;
    op_new.has_second = 1'b0;
    op_new.at_loop    = 1'b0;
    unique case (phase)
      vgmct_pkg::PH_CMD: begin
        gen            = 1'b1;
        op_new.at_loop = at_loop;
        op_new.kind    = vgmct_pkg::OP_CMD;
        unique case (song_byte)
          vgmct_pkg::CMD_REG_WR: op_new.first = vgmct_pkg::OUT_REG_WR;
          vgmct_pkg::CMD_WAIT_N: op_new.first = vgmct_pkg::OUT_WAIT;
          vgmct_pkg::CMD_WAIT_NTSC, vgmct_pkg::CMD_WAIT_PAL: begin
            op_new.first      = vgmct_pkg::OUT_WAIT;
            op_new.second     = vgmct_pkg::ONE_FRAME;
            op_new.has_second = 1'b1;
          end
          vgmct_pkg::CMD_DATA_BLK: begin
            op_new.first      = vgmct_pkg::OUT_REG_WR;
            op_new.second     = sync_reg;
            op_new.has_second = 1'b1;
          end
          vgmct_pkg::CMD_END: begin
            op_new.kind  = vgmct_pkg::OP_END;
            op_new.first = (loop_offset != 32'd0) ? vgmct_pkg::OUT_LOOP
                                                  : vgmct_pkg::OUT_END;
          end
          default: op_new.kind = vgmct_pkg::OP_BAD;
        endcase
      end
      vgmct_pkg::PH_WR_ADDR: begin
        gen          = 1'b1;
        op_new.first = song_byte + vgmct_pkg::ADDR_BIAS;
      end
      vgmct_pkg::PH_WR_VAL, vgmct_pkg::PH_DB_VAL: gen = 1'b1;
      vgmct_pkg::PH_WAIT_HI: begin
        gen           = 1'b1;
        op_new.kind   = vgmct_pkg::OP_WAIT;
        op_new.first  = wait_lo;
        op_new.second = song_byte;
      end
      default: gen = 1'b0;
    endcase
  end

  assign op_push  = accept & gen;
  assign full     = (count == (vgmct_pkg::QPTR_W+1)'(vgmct_pkg::QUEUE_DEPTH));
  assign op_valid = (count != '0);
  assign op       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= vgmct_pkg::PH_CMD;
      skip_count    <= '0;
      wait_lo       <= '0;
      stream_offset <= vgmct_pkg::START_OFFSET;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      phase      <= phase_next;
      skip_count <= skip_next;
      wait_lo    <= wait_lo_next;
      if (accept) begin
        stream_offset <= stream_offset + 32'd1;
      end
      if (op_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (op_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (vgmct_pkg::QPTR_W+1)'(op_push) - (vgmct_pkg::QPTR_W+1)'(op_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (op_push) begin
      q_mem[wr_ptr] <= op_new;
    end
  end

endmodule

FILE: src/vgmct_back.sv
// Back end: bank tracking, frame-count arithmetic and the result queue.
module vgmct_back (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       tick_rate,
  input  logic             op_valid,
  input  vgmct_pkg::op_t   op,
  output logic             op_pop,
  output logic             res_empty,
  input  logic             res_pop,
  output vgmct_pkg::res_t  res
);

  vgmct_pkg::bk_state_t state, state_next;
  vgmct_pkg::op_t       cur;
  logic        halted;
  logic [7:0]  bank;
  logic [13:0] pos;

  logic [23:0] num;
  logic [8:0]  q_est;
  logic [16:0] rem;
  logic [40:0] recip_prod;
  logic [24:0] back_prod;

  logic        room_needed;
  logic        bank_out;
  logic        out_ok;
  logic        rem_hi;
  logic [9:0]  q_fix;
  logic [15:0] r_fix;
  logic        exact;
  logic        round_up;
  logic [9:0]  q_final;

  logic            emit;
  vgmct_pkg::res_t res_new;
  logic            halt_set;
  logic            bank_inc;

  vgmct_pkg::res_t              r_mem [vgmct_pkg::QUEUE_DEPTH];
  logic [vgmct_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [vgmct_pkg::QPTR_W:0]   count;
  logic                         do_pop;

  function automatic vgmct_pkg::res_t make_res(
    input logic             valid,
    input logic [7:0]       b,
    input logic             lp,
    input logic             done,
    input vgmct_pkg::fault_t flt,
    input logic             last,
    input logic [7:0]       bk,
    input logic [13:0]      ps
  );
    vgmct_pkg::res_t r;
    r.byte_valid       = valid;
    r.emitted_byte     = valid ? b : 8'd0;
    r.bank_number      = bk;
    r.bank_position    = ps;
    r.loop_seen        = lp;
    r.loop_cpu_address = lp ? {1'b1, ps} : 15'd0;
    r.loop_bank        = lp ? bk + 8'd1 : 8'd0;
    r.song_done        = done;
    r.fault            = flt;
    r.run_last         = last;
    return r;
  endfunction

  assign out_ok      = (count != (vgmct_pkg::QPTR_W+1)'(vgmct_pkg::QUEUE_DEPTH));
  assign room_needed = ({1'b0, pos} + 15'd4) > vgmct_pkg::BANK_BYTES;
  assign bank_out    = ({1'b0, bank} + 9'd1) >= vgmct_pkg::MAX_BANKS;

  assign recip_prod = 41'(num) * 41'(vgmct_pkg::DIV_RECIP);
  assign back_prod  = 25'(q_est) * 25'(vgmct_pkg::FRAME_DIV);

  // reciprocal estimate is at most one low
  assign rem_hi   = rem >= {1'b0, vgmct_pkg::FRAME_DIV};
  assign q_fix    = rem_hi ? {1'b0, q_est} + 10'd1 : {1'b0, q_est};
  assign r_fix    = rem_hi ? 16'(rem - {1'b0, vgmct_pkg::FRAME_DIV}) : rem[15:0];
  assign exact    = (r_fix == 16'd0);
  assign round_up = (r_fix >= vgmct_pkg::ROUND_MIN);
  assign q_final  = (!exact && round_up) ? q_fix + 10'd1 : q_fix;

  always_comb begin
    state_next = state;
    unique case (state)
      vgmct_pkg::BK_IDLE: begin
        if (op_valid && !halted) begin
          unique case (op.kind)
            vgmct_pkg::OP_CMD:  state_next = vgmct_pkg::BK_ROOM;
            vgmct_pkg::OP_WAIT: state_next = vgmct_pkg::BK_MUL;
            default:            state_next = vgmct_pkg::BK_FIRST;
          endcase
        end
      end
      vgmct_pkg::BK_ROOM: begin
        if (!room_needed) begin
          state_next = vgmct_pkg::BK_FIRST;
        end else if (out_ok) begin
          state_next = bank_out ? vgmct_pkg::BK_IDLE : vgmct_pkg::BK_FIRST;
        end
      end
      vgmct_pkg::BK_FIRST: begin
        if (out_ok) begin
          state_next = (cur.kind == vgmct_pkg::OP_CMD && cur.has_second) ?
                       vgmct_pkg::BK_SECOND : vgmct_pkg::BK_IDLE;
        end
      end
      vgmct_pkg::BK_SECOND: if (out_ok) state_next = vgmct_pkg::BK_IDLE;
      vgmct_pkg::BK_MUL:    state_next = vgmct_pkg::BK_DIV;
      vgmct_pkg::BK_DIV:    state_next = vgmct_pkg::BK_REM;
      vgmct_pkg::BK_REM:    state_next = vgmct_pkg::BK_FIX;
      vgmct_pkg::BK_FIX:    if (out_ok) state_next = vgmct_pkg::BK_IDLE;
      default:              state_next = vgmct_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    op_pop   = 1'b0;
    halt_set = 1'b0;
    bank_inc = 1'b0;
    res_new  = make_res(1'b0, 8'd0, 1'b0, 1'b0, vgmct_pkg::FLT_NONE, 1'b1, bank, pos);
    unique case (state)
      vgmct_pkg::BK_IDLE: op_pop = op_valid;
      vgmct_pkg::BK_ROOM: begin
        if (room_needed && out_ok) begin
          emit = 1'b1;
          if (bank_out) begin
            halt_set = 1'b1;
            res_new  = make_res(1'b0, 8'd0, 1'b0, 1'b0, vgmct_pkg::FLT_RANGE, 1'b1,
                                bank, pos);
          end else begin
            bank_inc = 1'b1;
            res_new  = make_res(1'b1, vgmct_pkg::OUT_BANK_SW, 1'b0, 1'b0,
                                vgmct_pkg::FLT_NONE, 1'b0, bank, pos);
          end
        end
      end
      vgmct_pkg::BK_FIRST: begin
        if (out_ok) begin
          emit = 1'b1;
          unique case (cur.kind)
            vgmct_pkg::OP_CMD: res_new = make_res(1'b1, cur.first, cur.at_loop, 1'b0,
                                 vgmct_pkg::FLT_NONE, !cur.has_second, bank, pos);
            vgmct_pkg::OP_END: begin
              halt_set = 1'b1;
              res_new  = make_res(1'b1, cur.first, cur.at_loop, 1'b1,
                                  vgmct_pkg::FLT_NONE, 1'b1, bank, pos);
            end
            vgmct_pkg::OP_BAD: begin
              halt_set = 1'b1;
              res_new  = make_res(1'b0, 8'd0, 1'b0, 1'b0, vgmct_pkg::FLT_UNKNOWN, 1'b1,
                                  bank, pos);
            end
            vgmct_pkg::OP_DATA: res_new = make_res(1'b1, cur.first, 1'b0, 1'b0,
                                  vgmct_pkg::FLT_NONE, 1'b1, bank, pos);
            default: emit = 1'b0;
          endcase
        end
      end
      vgmct_pkg::BK_SECOND: begin
        if (out_ok) begin
          emit    = 1'b1;
          res_new = make_res(1'b1, cur.second, 1'b0, 1'b0, vgmct_pkg::FLT_NONE, 1'b1,
                             bank, pos);
        end
      end
      vgmct_pkg::BK_FIX: begin
        if (out_ok) begin
          emit = 1'b1;
          if (!exact && !round_up) begin
            halt_set = 1'b1;
            res_new  = make_res(1'b0, 8'd0, 1'b0, 1'b0, vgmct_pkg::FLT_INEXACT, 1'b1,
                                bank, pos);
          end else if (q_final > vgmct_pkg::FRAME_MAX) begin
            halt_set = 1'b1;
            res_new  = make_res(1'b0, 8'd0, 1'b0, 1'b0, vgmct_pkg::FLT_RANGE, 1'b1,
                                bank, pos);
          end else begin
            res_new  = make_res(1'b1, q_final[7:0], 1'b0, 1'b0, vgmct_pkg::FLT_NONE,
                                1'b1, bank, pos);
          end
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign do_pop    = res_pop & ~res_empty;
  assign res_empty = (count == '0);
  assign res       = r_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= vgmct_pkg::BK_IDLE;
      halted <= 1'b0;
      bank   <= '0;
      pos    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      state <= state_next;
      if (halt_set) begin
        halted <= 1'b1;
      end
      if (bank_inc) begin
        bank <= bank + 8'd1;
        pos  <= '0;
      end else if (emit && res_new.byte_valid) begin
        pos <= pos + 14'd1;
      end
      if (emit) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (vgmct_pkg::QPTR_W+1)'(emit) - (vgmct_pkg::QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop) begin
      cur <= op;
    end
    if (state == vgmct_pkg::BK_MUL) begin
      num <= {cur.second, cur.first} * 24'(tick_rate);
    end
    if (state == vgmct_pkg::BK_DIV) begin
      q_est <= recip_prod[40:32];
    end
    if (state == vgmct_pkg::BK_REM) begin
      rem <= 17'({1'b0, num} - back_prod);
    end
    if (emit) begin
      r_mem[wr_ptr] <= res_new;
    end
  end

endmodule

FILE: src/vgm_command_transcoder.sv
// Top level of the VGM command transcoder.
// Song bytes (first byte at file offset 0xC0) go in through push/full and come
// out as a banked engine command stream through empty/pop, one item per output
// byte or fault, with run_last marking the last item of each song byte. A byte
// is taken whenever the four-entry operation queue has room; the executor
// behind it picks up an operation, checks the bank room for a command, then
// emits its items in turn, and handles a sample wait's high byte in the steps
// pick-up, multiply, reciprocal multiply, remainder, then correct and emit. A
// register write has 3 song bytes, and an NTSC/PAL wait a single one. After
// the song end or any fault, later bytes are still taken but give no items
// until reset.
module vgm_command_transcoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  input  logic [7:0]  song_byte,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic        byte_valid,
  output logic [7:0]  emitted_byte,
  output logic [7:0]  bank_number,
  output logic [13:0] bank_position,
  output logic        loop_seen,
  output logic [14:0] loop_cpu_address,
  output logic [7:0]  loop_bank,
  output logic        song_done,
  output logic [1:0]  fault,
  output logic        run_last
);

  logic [7:0]      tick_rate;
  logic [31:0]     loop_offset;
  logic [7:0]      sync_reg;
  logic            op_valid;
  logic            op_pop;
  vgmct_pkg::op_t  op;
  vgmct_pkg::res_t res;

  vgmct_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .tick_rate   (tick_rate),
    .loop_offset (loop_offset),
    .sync_reg    (sync_reg)
  );

  vgmct_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .song_byte   (song_byte),
    .full        (full),
    .loop_offset (loop_offset),
    .sync_reg    (sync_reg),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop)
  );

  vgmct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tick_rate   (tick_rate),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop),
    .res_empty   (empty),
    .res_pop     (pop),
    .res         (res)
  );

  assign byte_valid       = res.byte_valid;
  assign emitted_byte     = res.emitted_byte;
  assign bank_number      = res.bank_number;
  assign bank_position    = res.bank_position;
  assign loop_seen        = res.loop_seen;
  assign loop_cpu_address = res.loop_cpu_address;
  assign loop_bank        = res.loop_bank;
  assign song_done        = res.song_done;
  assign fault            = res.fault;
  assign run_last         = res.run_last;

endmodule

FILE: src/vgmct_checker.sv
// Port-level checks of the transcoder, bound to the top level.
module vgmct_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        byte_valid,
  input logic [7:0]  emitted_byte,
  input logic [7:0]  bank_number,
  input logic [13:0] bank_position,
  input logic        loop_seen,
  input logic [14:0] loop_cpu_address,
  input logic [7:0]  loop_bank,
  input logic [1:0]  fault,
  input logic        run_last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_fault_no_byte: assert property (@(posedge clk) disable iff (rst)
    (!empty && fault != 2'd0) |-> !byte_valid)
    else $error("fault item carries a byte");

  a_bare_item_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (emitted_byte == 8'd0 && run_last))
    else $error("item without byte is not clean or not last");

  a_loop_addr: assert property (@(posedge clk) disable iff (rst)
    (!empty && loop_seen) |->
      (loop_cpu_address == {1'b1, bank_position} && loop_bank == bank_number + 8'd1))
    else $error("loop address does not match item position");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(emitted_byte)))
    else $error("waiting item changed while stalled");

endmodule

bind vgm_command_transcoder vgmct_checker u_checker (.*);

FILE: tb/vgm_command_transcoder_tb.sv
// Self-checking testbench for the VGM command transcoder: directed and random song streams.
`timescale 1ns / 1ps

module vgm_command_transcoder_tb;

  localparam logic [31:0] FIRST_OFFSET = 32'h0000_00C0;
  localparam int unsigned SAMPLE_RATE  = 44100;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MIX_BYTES    = 80;
  localparam longint unsigned RUN_LIMIT_NS = 64'd12 * 64'd200_000;

  typedef enum int {
    END_SONG,
    BAD_COMMAND,
    INEXACT_WAIT,
    FRAME_OVERFLOW
  } finish_kind_t;

  class transcoder_checker;
    logic [7:0]  rate;
    logic [31:0] loop_ofs;
    logic [7:0]  sync_addr;
    vgmct_pkg::phase_t phase;
    logic [31:0] offset;
    logic [7:0]  bank;
    logic [13:0] pos;
    logic [7:0]  wait_lo;
    logic [3:0]  skip_left;
    logic        halted;
    vgmct_pkg::res_t step_items[$];
    vgmct_pkg::res_t expected_items[$];
    int          mismatches;

    function new();
      rate = 8'd50;
      loop_ofs = '0;
      sync_addr = 8'd128;
      phase = vgmct_pkg::PH_CMD;
      offset = FIRST_OFFSET;
      bank = '0;
      pos = '0;
      wait_lo = '0;
      skip_left = '0;
      halted = 1'b0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        vgmct_pkg::REG_TICK_RATE: rate = val[7:0];
        vgmct_pkg::REG_LOOP_OFS:  loop_ofs = val;
        vgmct_pkg::REG_SYNC:      sync_addr = val[7:0];
        default: ;
      endcase
    endfunction

    function void emit(logic valid, logic [7:0] value, logic mark, logic done,
                       vgmct_pkg::fault_t f);
      vgmct_pkg::res_t r;
      r.byte_valid = valid;
      r.emitted_byte = valid ? value : 8'h00;
      r.bank_number = bank;
      r.bank_position = pos;
      r.loop_seen = mark;
      r.loop_cpu_address = mark ? ({1'b0, pos} + 15'h4000) : 15'h0000;
      r.loop_bank = mark ? bank + 8'd1 : 8'h00;
      r.song_done = done;
      r.fault = f;
      r.run_last = 1'b0;
      step_items.push_back(r);
      if (valid) pos++;
    endfunction

    function void halt_with(vgmct_pkg::fault_t f);
      emit(1'b0, 8'h00, 1'b0, 1'b0, f);
      halted = 1'b1;
    endfunction

    // Works out the items caused by one accepted song byte.
    function void accept_byte(logic [7:0] b);
      logic        at_loop;
      logic [31:0] prod;
      logic [31:0] quo;
      logic [31:0] rem;
      vgmct_pkg::res_t r;
      at_loop = (loop_ofs != 32'h0) && (offset == loop_ofs);
      step_items.delete();
      if (halted) return;
      offset++;
      case (phase)
        vgmct_pkg::PH_CMD: begin
          if (b inside {vgmct_pkg::CMD_REG_WR, vgmct_pkg::CMD_WAIT_N,
                        vgmct_pkg::CMD_WAIT_NTSC, vgmct_pkg::CMD_WAIT_PAL,
                        vgmct_pkg::CMD_DATA_BLK}) begin
            // a command that may not fit closes the bank first
            if (({1'b0, pos} + 15'd4) > vgmct_pkg::BANK_BYTES) begin
              if (({1'b0, bank} + 9'd1) >= vgmct_pkg::MAX_BANKS) begin
                halt_with(vgmct_pkg::FLT_RANGE);
              end else begin
                emit(1'b1, vgmct_pkg::OUT_BANK_SW, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
                bank++;
                pos = '0;
              end
            end
            if (!halted) begin
              case (b)
                vgmct_pkg::CMD_REG_WR: begin
                  emit(1'b1, vgmct_pkg::OUT_REG_WR, at_loop, 1'b0, vgmct_pkg::FLT_NONE);
                  phase = vgmct_pkg::PH_WR_ADDR;
                end
                vgmct_pkg::CMD_WAIT_N: begin
                  emit(1'b1, vgmct_pkg::OUT_WAIT, at_loop, 1'b0, vgmct_pkg::FLT_NONE);
                  phase = vgmct_pkg::PH_WAIT_LO;
                end
                vgmct_pkg::CMD_DATA_BLK: begin
                  emit(1'b1, vgmct_pkg::OUT_REG_WR, at_loop, 1'b0, vgmct_pkg::FLT_NONE);
                  emit(1'b1, sync_addr, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
                  skip_left = 4'd8;
                  phase = vgmct_pkg::PH_SKIP;
                end
                default: begin
                  emit(1'b1, vgmct_pkg::OUT_WAIT, at_loop, 1'b0, vgmct_pkg::FLT_NONE);
                  emit(1'b1, vgmct_pkg::ONE_FRAME, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
                end
              endcase
            end
          end else if (b == vgmct_pkg::CMD_END) begin
            emit(1'b1, (loop_ofs != 32'h0) ? vgmct_pkg::OUT_LOOP : vgmct_pkg::OUT_END,
                 at_loop, 1'b1, vgmct_pkg::FLT_NONE);
            halted = 1'b1;
          end else begin
            halt_with(vgmct_pkg::FLT_UNKNOWN);
          end
        end
        vgmct_pkg::PH_WR_ADDR: begin
          emit(1'b1, b + vgmct_pkg::ADDR_BIAS, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
          phase = vgmct_pkg::PH_WR_VAL;
        end
        vgmct_pkg::PH_WR_VAL: begin
          emit(1'b1, b, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
          phase = vgmct_pkg::PH_CMD;
        end
        vgmct_pkg::PH_WAIT_LO: begin
          wait_lo = b;
          phase = vgmct_pkg::PH_WAIT_HI;
        end
        vgmct_pkg::PH_WAIT_HI: begin
          phase = vgmct_pkg::PH_CMD;
          prod = {16'h0000, b, wait_lo} * {24'h000000, rate};
          quo = prod / SAMPLE_RATE;
          rem = prod % SAMPLE_RATE;
          // only a fraction of 0.99 or more is rounded up
          if (rem != 32'h0 && rem * 32'd100 < 32'd99 * SAMPLE_RATE) begin
            halt_with(vgmct_pkg::FLT_INEXACT);
          end else begin
            if (rem != 32'h0) quo++;
            if (quo > 32'd255) halt_with(vgmct_pkg::FLT_RANGE);
            else emit(1'b1, quo[7:0], 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
          end
        end
        vgmct_pkg::PH_SKIP: begin
          if (skip_left != 4'd0) skip_left--;
          if (skip_left == 4'd0) phase = vgmct_pkg::PH_DB_VAL;
        end
        vgmct_pkg::PH_DB_VAL: begin
          emit(1'b1, b, 1'b0, 1'b0, vgmct_pkg::FLT_NONE);
          phase = vgmct_pkg::PH_CMD;
        end
        default: phase = vgmct_pkg::PH_CMD;
      endcase
      foreach (step_items[i]) begin
        r = step_items[i];
        r.run_last = (i == step_items.size() - 1);
        expected_items.push_back(r);
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_item(vgmct_pkg::res_t got);
      vgmct_pkg::res_t want;
      if (expected_items.size() == 0) begin
        $error("item with nothing expected: byte 0x%0h fault %0d",
               got.emitted_byte, got.fault);
        mismatches++;
        return;
      end
      want = expected_items.pop_front();
      compare("byte_valid", want.byte_valid, got.byte_valid);
      compare("emitted_byte", want.emitted_byte, got.emitted_byte);
      compare("bank_number", want.bank_number, got.bank_number);
      compare("bank_position", want.bank_position, got.bank_position);
      compare("loop_seen", want.loop_seen, got.loop_seen);
      compare("loop_cpu_address", want.loop_cpu_address, got.loop_cpu_address);
      compare("loop_bank", want.loop_bank, got.loop_bank);
      compare("song_done", want.song_done, got.song_done);
      compare("fault", want.fault, got.fault);
      compare("run_last", want.run_last, got.run_last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic [7:0]  song_byte = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic        byte_valid;
  logic [7:0]  emitted_byte;
  logic [7:0]  bank_number;
  logic [13:0] bank_position;
  logic        loop_seen;
  logic [14:0] loop_cpu_address;
  logic [7:0]  loop_bank;
  logic        song_done;
  logic [1:0]  fault;
  logic        run_last;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_in = 0;

  transcoder_checker chk = new();

  vgm_command_transcoder dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .push(push),
    .song_byte(song_byte),
    .full(full),
    .empty(empty),
    .pop(pop),
    .byte_valid(byte_valid),
    .emitted_byte(emitted_byte),
    .bank_number(bank_number),
    .bank_position(bank_position),
    .loop_seen(loop_seen),
    .loop_cpu_address(loop_cpu_address),
    .loop_bank(loop_bank),
    .song_done(song_done),
    .fault(fault),
    .run_last(run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // push stays high after acceptance so the next item can follow back to back
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    song_byte = b;
    do @(posedge clk); while (full);
    chk.accept_byte(b);
    bytes_in++;
  endtask

  task automatic push_wait(input logic [15:0] samples);
    push_byte(vgmct_pkg::CMD_WAIT_N);
    push_byte(samples[7:0]);
    push_byte(samples[15:8]);
  endtask

  // wait for every expected item, then give queued no-output bytes time to drain
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (chk.expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    chk.set_reg(idx, val);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(input logic [7:0] rate, input logic [31:0] loop_ofs,
                           input logic [7:0] sync_addr);
    settle();
    write_reg(vgmct_pkg::REG_TICK_RATE, {24'h0, rate});
    write_reg(vgmct_pkg::REG_LOOP_OFS, loop_ofs);
    write_reg(vgmct_pkg::REG_SYNC, {24'h0, sync_addr});
  endtask

  // one well-formed command with random content
  task automatic send_command();
    int unsigned pick;
    int unsigned lim;
    int unsigned frames;
    pick = $urandom_range(99);
    if (pick < 40) begin
      push_byte(vgmct_pkg::CMD_REG_WR);
      push_byte(8'($urandom));
      push_byte(8'($urandom));
    end else if (pick < 60) begin
      // floor(frames * 44100 / rate) always lands on an exact or rounded count
      lim = 65535 * int'(chk.rate) / SAMPLE_RATE;
      if (lim > 255) lim = 255;
      frames = $urandom_range(lim, 0);
      push_wait(16'(frames * SAMPLE_RATE / int'(chk.rate)));
    end else if (pick < 70) begin
      push_byte(vgmct_pkg::CMD_WAIT_NTSC);
    end else if (pick < 80) begin
      push_byte(vgmct_pkg::CMD_WAIT_PAL);
    end else begin
      push_byte(vgmct_pkg::CMD_DATA_BLK);
      repeat (8) push_byte(8'($urandom));
      push_byte(8'($urandom));
    end
  endtask

  task automatic run_mix(input int unsigned send_pct, input int unsigned recv_pct,
                         input int unsigned n);
    int unsigned start;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    start = bytes_in;
    while (bytes_in - start < n) send_command();
  endtask

  initial begin
    vgmct_pkg::res_t got;
    forever begin
      @(negedge clk);
      pop = ($urandom_range(99) >= recv_stall_pct);
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got.byte_valid = byte_valid;
        got.emitted_byte = emitted_byte;
        got.bank_number = bank_number;
        got.bank_position = bank_position;
        got.loop_seen = loop_seen;
        got.loop_cpu_address = loop_cpu_address;
        got.loop_bank = loop_bank;
        got.song_done = song_done;
        got.fault = vgmct_pkg::fault_t'(fault);
        got.run_last = run_last;
        chk.check_item(got);
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    finish_kind_t kind;
    logic [7:0]   b;
    logic [15:0]  samples;
    logic [31:0]  prod;
    int unsigned  frames;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: loop point on the second register write
    configure(8'd50, FIRST_OFFSET + 32'd3, 8'h00);
    push_byte(vgmct_pkg::CMD_REG_WR);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(vgmct_pkg::CMD_REG_WR);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(vgmct_pkg::CMD_WAIT_NTSC);
    push_byte(vgmct_pkg::CMD_WAIT_PAL);
    push_wait(16'd0);
    push_wait(16'd881);       // 0.998 frame, rounds up
    push_byte(vgmct_pkg::CMD_DATA_BLK);
    repeat (8) push_byte(8'($urandom));
    push_byte(8'h5A);
    configure(8'd1, 32'h0, 8'hFF);
    push_wait(16'd43659);     // remainder right at the round-up threshold

    configure(8'd255, 32'h0, 8'hFF);
    run_mix(0, 0, MIX_BYTES);
    configure(8'($urandom_range(255, 1)), chk.offset + $urandom_range(60, 1), 8'($urandom));
    run_mix(73, 0, MIX_BYTES);
    configure(8'($urandom_range(255, 1)), 32'hFFFF_FFFF, 8'($urandom));
    run_mix(0, 73, MIX_BYTES);
    configure(8'($urandom_range(255, 1)), chk.offset, 8'($urandom));
    run_mix(26, 26, MIX_BYTES);

    // the block halts for good, so exactly one way of ending is exercised per run
    kind = finish_kind_t'($urandom_range(3));
    case (kind)
      END_SONG: begin
        configure(chk.rate, ($urandom_range(1) != 0) ? chk.offset : 32'h0, chk.sync_addr);
        push_byte(vgmct_pkg::CMD_END);
      end
      BAD_COMMAND: begin
        do b = 8'($urandom);
        while (b inside {vgmct_pkg::CMD_REG_WR, vgmct_pkg::CMD_WAIT_N,
                         vgmct_pkg::CMD_WAIT_NTSC, vgmct_pkg::CMD_WAIT_PAL,
                         vgmct_pkg::CMD_END, vgmct_pkg::CMD_DATA_BLK});
        push_byte(b);
      end
      INEXACT_WAIT: begin
        do begin
          samples = 16'($urandom_range(65535, 1));
          prod = {16'h0000, samples} * {24'h000000, chk.rate};
        end while (prod % SAMPLE_RATE == 0 ||
                   (prod % SAMPLE_RATE) * 32'd100 >= 32'd99 * SAMPLE_RATE);
        push_wait(samples);
      end
      default: begin
        configure(8'd255, chk.loop_ofs, chk.sync_addr);
        frames = $urandom_range(378, 256);
        push_wait(16'(frames * SAMPLE_RATE / 255));
      end
    endcase
    send_idle_pct = 50;
    repeat (5) push_byte(8'($urandom));

    recv_stall_pct = 0;
    settle();
    if (chk.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
